/* design/tsl_pkg.sv */
// Shared constants and class codes for the throttle slew limiter.
`default_nettype none

package tsl_pkg;

  // Sample width default; the top level carries it as a parameter.
  localparam int SAMPLE_BITS_DEF = 10;

  // Q16 duty format: 65536 means 1.0, so a duty needs 17 bits.
  localparam int DUTY_W    = 17;
  localparam int FRAC_BITS = 16;
  localparam int ITER_W    = 4;

  localparam logic [DUTY_W-1:0] Q16_ONE    = 17'd65536;
  localparam logic [DUTY_W-1:0] ON_LEVEL   = 17'd9830;
  localparam logic [DUTY_W-1:0] OFF_LEVEL  = 17'd7865;
  localparam logic [DUTY_W-1:0] DUTY_CEIL  = 17'd62259;
  localparam logic [DUTY_W-1:0] STEP_RESET = 17'd655;

  localparam int IN_MIN_RESET = 0;
  localparam int IN_MAX_RESET = 1023;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 2'd2;

  // Classes that the front end assigns to a sample.
  localparam int CLS_W = 2;
  localparam logic [CLS_W-1:0] CLS_ZERO = 2'd0;
  localparam logic [CLS_W-1:0] CLS_FULL = 2'd1;
  localparam logic [CLS_W-1:0] CLS_DIV  = 2'd2;

  // Depth of the queue between front and back end.
  localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

/* design/tsl_queue.sv */
// Small register queue that decouples the front end from the back end.
`default_nettype none

module tsl_queue #(
  parameter int WIDTH = 22,
  parameter int DEPTH = tsl_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output      logic             q_full,
  input  wire logic             rd_en,
  output      logic [WIDTH-1:0] rd_data,
  output      logic             q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/tsl_front.sv */
// Front end: configuration registers and classification of each sample.
`default_nettype none

module tsl_front #(
  parameter int SAMPLE_BITS = tsl_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr,
  input  wire logic [tsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsl_pkg::DUTY_W-1:0]     cfg_data,
  input  wire logic [SAMPLE_BITS-1:0]         sample,
  output      logic [tsl_pkg::CLS_W-1:0]      cls,
  output      logic [SAMPLE_BITS-1:0]         num,
  output      logic [SAMPLE_BITS-1:0]         den,
  output      logic [tsl_pkg::DUTY_W-1:0]     ramp_step
);

  localparam logic [SAMPLE_BITS-1:0] MinReset = SAMPLE_BITS'(tsl_pkg::IN_MIN_RESET);
  localparam logic [SAMPLE_BITS-1:0] MaxReset = SAMPLE_BITS'(tsl_pkg::IN_MAX_RESET);

  logic [SAMPLE_BITS-1:0] input_min;
  logic [SAMPLE_BITS-1:0] input_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_min <= MinReset;
      input_max <= MaxReset;
      ramp_step <= tsl_pkg::STEP_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        tsl_pkg::REG_INPUT_MIN: input_min <= cfg_data[SAMPLE_BITS-1:0];
        tsl_pkg::REG_INPUT_MAX: input_max <= cfg_data[SAMPLE_BITS-1:0];
        tsl_pkg::REG_RAMP_STEP: ramp_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // An empty range or a sample at or below the minimum gives zero; at or above
  // the maximum gives full scale. Only samples strictly inside need a divide,
  // and then the numerator is always below the denominator.
  always_comb begin
    num = sample - input_min;
    den = input_max - input_min;
    if ((input_max <= input_min) || (sample <= input_min)) begin
      cls = tsl_pkg::CLS_ZERO;
    end else if (sample >= input_max) begin
      cls = tsl_pkg::CLS_FULL;
    end else begin
      cls = tsl_pkg::CLS_DIV;
    end
  end

endmodule

`default_nettype wire

/* design/tsl_back.sv */
// Back end: iterative divide, hysteresis flag, slew limit and result register.
`default_nettype none

module tsl_back #(
  parameter int SAMPLE_BITS = tsl_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_empty,
  input  wire logic [tsl_pkg::CLS_W-1:0]   q_cls,
  input  wire logic [SAMPLE_BITS-1:0]      q_num,
  input  wire logic [SAMPLE_BITS-1:0]      q_den,
  output      logic                        q_pop,
  input  wire logic [tsl_pkg::DUTY_W-1:0]  ramp_step,
  input  wire logic                        pop,
  output      logic                        empty,
  output      logic [tsl_pkg::DUTY_W-1:0]  duty,
  output      logic [tsl_pkg::DUTY_W-1:0]  target_duty,
  output      logic                        enabled
);

  localparam int DW = tsl_pkg::DUTY_W;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [tsl_pkg::ITER_W-1:0] IterLast = tsl_pkg::ITER_W'(tsl_pkg::FRAC_BITS - 1);

  logic [1:0]                  state;
  logic [tsl_pkg::ITER_W-1:0]  iter;
  logic [SAMPLE_BITS-1:0]      rem;
  logic [SAMPLE_BITS-1:0]      den;
  logic [DW-1:0]               tgt;
  logic [DW-1:0]               current_duty;
  logic                        active;
  logic                        res_valid;

  logic [SAMPLE_BITS:0]        rem2;
  logic                        qbit;
  logic                        out_free;
  logic                        act_next;
  logic [DW-1:0]               gap;
  logic [DW:0]                 moved;
  logic [DW-1:0]               duty_next;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign empty    = !res_valid;
  assign out_free = !res_valid || pop;

  // One restoring-divide step: remainder stays below the divisor throughout.
  assign rem2 = {rem, 1'b0};
  assign qbit = (rem2 >= {1'b0, den});

  always_comb begin
    act_next = active || (tgt > tsl_pkg::ON_LEVEL);
    if (tgt < tsl_pkg::OFF_LEVEL) begin
      act_next = 1'b0;
    end
    gap = (tgt > current_duty) ? (tgt - current_duty) : (current_duty - tgt);
    if (tgt > current_duty) begin
      moved = {1'b0, current_duty} + {1'b0, ramp_step};
      if (moved > {1'b0, tgt}) begin
        moved = {1'b0, tgt};
      end
    end else begin
      moved = {1'b0, current_duty} - {1'b0, ramp_step};
      if (moved < {1'b0, tgt}) begin
        moved = {1'b0, tgt};
      end
    end
    if (moved > {1'b0, tsl_pkg::DUTY_CEIL}) begin
      moved = {1'b0, tsl_pkg::DUTY_CEIL};
    end
    if (!act_next) begin
      duty_next = '0;
    end else if (gap < ramp_step) begin
      duty_next = tgt;
    end else begin
      duty_next = moved[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rem  <= q_num;
        den  <= q_den;
        iter <= '0;
        case (q_cls)
          tsl_pkg::CLS_FULL: tgt <= tsl_pkg::Q16_ONE;
          default:           tgt <= '0;
        endcase
      end
      ST_DIV: begin
        rem  <= qbit ? SAMPLE_BITS'(rem2 - {1'b0, den}) : rem2[SAMPLE_BITS-1:0];
        tgt  <= {tgt[DW-2:0], qbit};
        iter <= iter + 1'b1;
      end
      default: ;
    endcase
    if ((state == ST_FIN) && out_free) begin
      duty        <= duty_next;
      target_duty <= tgt;
      enabled     <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      current_duty <= '0;
      active       <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= (q_cls == tsl_pkg::CLS_DIV) ? ST_DIV : ST_FIN;
          end
        end
        ST_DIV: begin
          if (iter == IterLast) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if ((state == ST_FIN) && out_free) begin
        current_duty <= duty_next;
        active       <= act_next;
        res_valid    <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < den))
    else $error("divide remainder reached the divisor");

  a_off_means_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !enabled) |-> (duty == '0))
    else $error("duty nonzero while disabled");

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (target_duty <= tsl_pkg::Q16_ONE))
    else $error("target duty above full scale");

  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FIN) && out_free) |=> ((state == ST_IDLE) && res_valid))
    else $error("finished request did not reach the result register");

  a_state_matches: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (duty == current_duty && enabled == active))
    else $error("result register out of step with slew state");

endmodule

`default_nettype wire

/* design/throttle_slew_limiter_top.sv */
// Top level of the throttle slew limiter: config port, front end, queue, back end.
`default_nettype none

//  Channel   Signals                                   Direction  Handshake
//  ------    ----------------------------------------  ---------  -------------------------
//  input     push, full, sample                        in         taken on push && !full
//  result    empty, pop, duty, target_duty, enabled    out        taken on pop && !empty
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in         written on valid && ready
//
//  A request that needs a divide takes, in the back end, one step to load it from
//  the queue, 16 restoring-divide steps (one quotient bit each) and one step to
//  apply the hysteresis and slew. Samples that map to zero or full scale skip the
//  divide and take only the load and final steps. The shared divide loop sets the
//  sustained rate. Reset is synchronous; it restores the register defaults, clears
//  the slew duty and enable state, and empties the queue and the result register.
//  The two-entry queue accepts requests until full while a result waits to be
//  popped; the back end stalls only at its final step when the result is full.

module throttle_slew_limiter_top #(
  parameter int SAMPLE_BITS = tsl_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output      logic                           full,
  input  wire logic [SAMPLE_BITS-1:0]         sample,
  output      logic                           empty,
  input  wire logic                           pop,
  output      logic [tsl_pkg::DUTY_W-1:0]     duty,
  output      logic [tsl_pkg::DUTY_W-1:0]     target_duty,
  output      logic                           enabled,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [tsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsl_pkg::DUTY_W-1:0]     cfg_data
);

  // A queue entry holds the class code, the numerator and the denominator.
  localparam int ENTRY_W = tsl_pkg::CLS_W + 2 * SAMPLE_BITS;

  logic [tsl_pkg::CLS_W-1:0]   f_cls;
  logic [SAMPLE_BITS-1:0]      f_num;
  logic [SAMPLE_BITS-1:0]      f_den;
  logic [tsl_pkg::DUTY_W-1:0]  ramp_step;
  logic [ENTRY_W-1:0]          q_rd_data;
  logic                        q_empty;
  logic                        q_pop;

  // Config regs are always ready; users must write only while idle, unchecked.
  assign cfg_ready = 1'b1;

  tsl_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .cls       (f_cls),
    .num       (f_num),
    .den       (f_den),
    .ramp_step (ramp_step)
  );

  // The queue's full flag is the input channel's full.
  tsl_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (tsl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data ({f_cls, f_num, f_den}),
    .q_full  (full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .q_empty (q_empty)
  );

  tsl_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_cls       (q_rd_data[ENTRY_W-1 -: tsl_pkg::CLS_W]),
    .q_num       (q_rd_data[2*SAMPLE_BITS-1 -: SAMPLE_BITS]),
    .q_den       (q_rd_data[SAMPLE_BITS-1:0]),
    .q_pop       (q_pop),
    .ramp_step   (ramp_step),
    .pop         (pop),
    .empty       (empty),
    .duty        (duty),
    .target_duty (target_duty),
    .enabled     (enabled)
  );

endmodule

`default_nettype wire
